// File: hdl/subword_token_detokenizer_assert.svh
// Assertion macros for the detokenizer.
// Used by the top level; depends on nothing else.
`ifndef SUBWORD_TOKEN_DETOKENIZER_ASSERT_SVH
`define SUBWORD_TOKEN_DETOKENIZER_ASSERT_SVH
`define STD_ASSERT_IMPL(lbl, clk, rst_n, a, c) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (c)) \
        else $error("assertion failed");
`define STD_ASSERT_NEXT(lbl, clk, rst_n, a, c) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (c)) \
        else $error("assertion failed");
`endif

// File: hdl/std_pkg.sv
// Types, constants and the hex nibble decoder of the detokenizer.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none
package std_pkg;
    typedef enum logic [1:0] {
        ACT_LOAD_ENTRY = 2'd0,
        ACT_LOAD_BYTE  = 2'd1,
        ACT_DECODE     = 2'd2,
        ACT_END        = 2'd3
    } t_action;
    localparam logic [2:0] KIND_NORMAL  = 3'd1;
    localparam logic [2:0] KIND_UNKNOWN = 3'd2;
    localparam logic [2:0] KIND_CONTROL = 3'd3;
    localparam logic [2:0] KIND_BYTE    = 3'd6;
    localparam logic [1:0] REG_VOCAB = 2'd0;
    localparam logic [1:0] REG_CAP   = 2'd1;
    localparam logic [1:0] REG_STRIP = 2'd2;
    localparam logic [7:0] MARK0 = 8'hE2;
    localparam logic [7:0] MARK1 = 8'h96;
    localparam logic [7:0] MARK2 = 8'h81;
    localparam logic [7:0] SPACE = 8'h20;
    localparam logic [7:0] CH_LT = 8'h3C;
    localparam logic [7:0] CH_ZERO = 8'h30;
    localparam logic [7:0] CH_X = 8'h78;
    localparam logic [7:0] CH_GT = 8'h3E;
    localparam logic [5:0] BYTE_PIECE_LEN = 6'd6;
    function automatic logic [4:0] nibble_of(input logic [7:0] c);
        logic [4:0] r;
        r = 5'h10;
        if (c >= 8'h30 && c <= 8'h39) r = {1'b0, 4'(c - 8'h30)};
        else if (c >= 8'h41 && c <= 8'h46) r = {1'b0, 4'(c - 8'h37)};
        else if (c >= 8'h61 && c <= 8'h66) r = {1'b0, 4'(c - 8'h57)};
        return r;
    endfunction
endpackage
`default_nettype wire

// File: hdl/std_ram.sv
// Generic single-port RAM with registered read.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none
module std_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  wire                      i_clk,
    input  wire                      i_we,
    input  wire  [$clog2(DEPTH)-1:0] i_addr,
    input  wire  [WIDTH-1:0]         i_wdata,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    always_ff @(posedge i_clk) begin
        if (i_we) r_mem[i_addr] <= i_wdata;
        o_rdata <= r_mem[i_addr];
    end
endmodule
`default_nettype wire

// File: hdl/subword_token_detokenizer.sv
// Detokenizer top level: piece table, string memory and byte sequencer.
// Depends on std_pkg, std_ram and the assertion header.
// Usage: s_axis carries requests; tuser holds action (bits 1:0). tdata holds
// piece_index, piece_type, piece_length, piece_offset, byte_addr, data_byte,
// token_id from the low bit up. m_axis carries result requests: tdata holds
// out_byte, overflow, out_count; tuser holds byte_valid; tlast is last.
// Load actions write in the lookup state and return to idle, as does a
// skipped id. A decode reads each piece byte through string memory read,
// wait, capture, unescape and emit check, and emits each character through
// the output register; a byte piece first reads and parses its characters.
// The single string memory port paces the decode. An end action emits up
// to two held bytes and a final result.
// The block takes one request at a time and waits while the receiver
// stalls: a result is held in the output register until taken.
// Reset clears the sequence state, config and counters; data registers and memories are not cleared.
`timescale 1ns / 1ps
`default_nettype none
`include "subword_token_detokenizer_assert.svh"
module subword_token_detokenizer #(
    parameter int MAX_PIECES = 4096,
    parameter int STRING_BYTES = 65536,
    parameter int MAX_PIECE_BYTES = 60
) (
    input  wire         i_clk,
    input  wire         i_rst_n,
    input  wire         i_cfg_valid,
    output logic        o_cfg_ready,
    input  wire  [1:0]  i_cfg_index,
    input  wire  [16:0] i_cfg_data,
    input  wire         s_axis_tvalid,
    output logic        s_axis_tready,
    // piece_index, piece_type, piece_length, piece_offset, byte_addr,
    // data_byte, token_id, low bit up; 93 bits padded to 96
    input  wire  [95:0] s_axis_tdata,
    // action
    input  wire  [1:0]  s_axis_tuser,
    output logic        m_axis_tvalid,
    input  wire         m_axis_tready,
    // out_byte, overflow, out_count, low bit up; padded to 32
    output logic [31:0] m_axis_tdata,
    // byte_valid
    output logic        m_axis_tuser,
    output logic        m_axis_tlast
);
    import std_pkg::*;
    localparam int PW = $clog2(MAX_PIECES);
    localparam int SW = $clog2(STRING_BYTES);

    typedef enum logic [3:0] {
        S_IDLE, S_LOOK, S_ENTRY, S_RD, S_WAIT, S_GOT, S_BYTE, S_EMIT,
        S_FLUSH, S_FINAL, S_OUT
    } t_state;

    t_state r_state, r_ret;
    logic [95:0] r_data;
    logic [1:0] r_act;
    logic [12:0] r_vocab;
    logic [16:0] r_cap;
    logic r_strip;
    logic [1:0] r_hcnt;
    logic [16:0] r_raw;
    logic [15:0] r_chars;
    logic r_ovf, r_lead;
    logic [2:0] r_kind;
    logic [5:0] r_len, r_k;
    logic [SW-1:0] r_off;
    logic [7:0] r_hi, r_b;
    logic [1:0] r_pend;
    logic [7:0] r_pq [3];
    logic [1:0] r_pi;
    logic [7:0] r_obyte;
    logic r_ovalid, r_olast;

    wire [11:0] f_idx = r_data[11:0];
    wire [2:0] f_type = r_data[14:12];
    wire [5:0] f_len = r_data[20:15];
    wire [15:0] f_off = r_data[36:21];
    wire [15:0] f_baddr = r_data[52:37];
    wire [7:0] f_byte = r_data[60:53];
    wire [31:0] f_id = r_data[92:61];

    logic [2:0] w_kind;
    logic [5:0] w_len, w_lsat;
    logic [15:0] w_off;
    logic [7:0] w_sbyte;
    logic w_twe, w_swe;
    logic [PW-1:0] w_taddr;
    logic [SW-1:0] w_saddr;

    assign w_lsat = (f_len > 6'(MAX_PIECE_BYTES)) ? 6'(MAX_PIECE_BYTES) : f_len;
    assign w_twe = (r_state == S_LOOK) && (r_act == ACT_LOAD_ENTRY)
        && ({20'd0, f_idx} < 32'(MAX_PIECES));
    assign w_swe = (r_state == S_LOOK) && (r_act == ACT_LOAD_BYTE)
        && ({16'd0, f_baddr} < 32'(STRING_BYTES));
    assign w_taddr = (r_act == ACT_DECODE) ? PW'(f_id) : PW'(f_idx);
    assign w_saddr = (r_state == S_LOOK) ? SW'(f_baddr) : SW'(r_off + SW'(r_k));

    std_ram #(.WIDTH(25), .DEPTH(MAX_PIECES)) u_tab (
        .i_clk(i_clk), .i_we(w_twe), .i_addr(w_taddr),
        .i_wdata({f_type, w_lsat, f_off}), .o_rdata({w_kind, w_len, w_off}));
    std_ram #(.WIDTH(8), .DEPTH(STRING_BYTES)) u_str (
        .i_clk(i_clk), .i_we(w_swe), .i_addr(w_saddr),
        .i_wdata(f_byte), .o_rdata(w_sbyte));

    wire [17:0] w_cap = (r_cap > 17'd65536) ? 18'd65536 : {1'b0, r_cap};
    wire [4:0] w_nib = nibble_of(w_sbyte);

    assign s_axis_tready = (r_state == S_IDLE);
    assign o_cfg_ready = (r_state == S_IDLE);
    assign m_axis_tvalid = (r_state == S_OUT);
    assign m_axis_tdata = {7'd0, r_chars, r_ovf, r_obyte};
    assign m_axis_tuser = r_ovalid;
    assign m_axis_tlast = r_olast;

    // Character queue: r_pq[r_pi..r_pend-1] still to emit, then r_ret.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE; r_ret <= S_IDLE;
            r_vocab <= 13'd0; r_cap <= 17'd65536; r_strip <= 1'b1;
            r_hcnt <= 2'd0; r_raw <= 17'd0;
            r_chars <= 16'd0; r_ovf <= 1'b0; r_lead <= 1'b0;
            r_pend <= 2'd0; r_pi <= 2'd0;
        end else begin
            case (r_state)
                S_IDLE: begin
                    if (i_cfg_valid) begin
                        case (i_cfg_index)
                            REG_VOCAB: r_vocab <= i_cfg_data[12:0];
                            REG_CAP: r_cap <= i_cfg_data;
                            REG_STRIP: r_strip <= i_cfg_data[0];
                            default: ;
                        endcase
                    end
                    if (s_axis_tvalid) begin
                        r_data <= s_axis_tdata;
                        r_act <= s_axis_tuser;
                        r_state <= S_LOOK;
                    end
                end
                S_LOOK: begin
                    case (r_act)
                        ACT_DECODE: begin
                            if (r_ovf || f_id >= {19'd0, r_vocab}
                                || f_id >= 32'(MAX_PIECES)) r_state <= S_IDLE;
                            else r_state <= S_ENTRY;
                        end
                        ACT_END: begin
                            r_pq[0] <= MARK0; r_pq[1] <= MARK1;
                            r_pend <= r_hcnt; r_pi <= 2'd0;
                            r_ret <= S_FINAL; r_state <= S_EMIT;
                        end
                        default: r_state <= S_IDLE;
                    endcase
                end
                S_ENTRY: begin
                    r_kind <= w_kind; r_len <= w_len; r_off <= SW'(w_off);
                    r_k <= 6'd0;
                    if (w_kind == KIND_CONTROL || w_kind == KIND_UNKNOWN)
                        r_state <= S_IDLE;
                    else if (w_kind == KIND_BYTE) begin
                        r_state <= (w_len == BYTE_PIECE_LEN) ? S_RD : S_IDLE;
                    end else if ({12'd0, w_len} + 18'(r_raw) >= w_cap) begin
                        r_ovf <= 1'b1; r_state <= S_IDLE;
                    end else begin
                        r_raw <= r_raw + 17'(w_len);
                        r_state <= S_RD;
                    end
                end
                S_RD: begin
                    if (r_kind != KIND_BYTE && r_k == r_len) r_state <= S_IDLE;
                    else r_state <= S_WAIT;
                end
                S_WAIT: r_state <= (r_kind == KIND_BYTE) ? S_BYTE : S_GOT;
                S_BYTE: begin
                    r_k <= r_k + 6'd1;
                    case (r_k)
                        6'd0: r_state <= (w_sbyte == CH_LT) ? S_RD : S_IDLE;
                        6'd1: r_state <= (w_sbyte == CH_ZERO) ? S_RD : S_IDLE;
                        6'd2: r_state <= (w_sbyte == CH_X) ? S_RD : S_IDLE;
                        6'd3: begin
                            r_state <= w_nib[4] ? S_IDLE : S_RD;
                            r_hi <= {w_nib[3:0], 4'd0};
                        end
                        6'd4: begin
                            r_state <= w_nib[4] ? S_IDLE : S_RD;
                            r_hi <= r_hi | {4'd0, w_nib[3:0]};
                        end
                        default: begin
                            if (w_sbyte != CH_GT) r_state <= S_IDLE;
                            else if (18'(r_raw) + 18'd1 >= w_cap) begin
                                r_ovf <= 1'b1; r_state <= S_IDLE;
                            end else begin
                                r_raw <= r_raw + 17'd1;
                                r_b <= r_hi; r_kind <= KIND_NORMAL;
                                r_len <= BYTE_PIECE_LEN;
                                r_state <= S_FLUSH;
                            end
                        end
                    endcase
                end
                S_GOT: begin
                    r_b <= w_sbyte; r_k <= r_k + 6'd1;
                    r_state <= S_FLUSH;
                end
                S_FLUSH: begin
                    r_pi <= 2'd0; r_ret <= S_RD; r_state <= S_EMIT;
                    if (r_hcnt == 2'd1 && r_b == MARK1) begin
                        r_hcnt <= 2'd2; r_pend <= 2'd0;
                    end else if (r_hcnt == 2'd2 && r_b == MARK2) begin
                        r_hcnt <= 2'd0; r_pq[0] <= SPACE; r_pend <= 2'd1;
                    end else begin
                        r_pq[0] <= (r_hcnt == 2'd0) ? r_b : MARK0;
                        r_pq[1] <= (r_hcnt == 2'd1) ? r_b : MARK1;
                        r_pq[2] <= r_b;
                        if (r_b == MARK0) begin
                            r_pend <= r_hcnt; r_hcnt <= 2'd1;
                        end else begin
                            r_pend <= r_hcnt + 2'd1; r_hcnt <= 2'd0;
                        end
                    end
                end
                S_EMIT: begin
                    if (r_pi == r_pend) r_state <= r_ret;
                    else begin
                        r_pi <= r_pi + 2'd1;
                        r_lead <= 1'b1;
                        if (!(!r_lead && r_strip && r_pq[r_pi] == SPACE)) begin
                            r_chars <= r_chars + 16'd1;
                            r_obyte <= r_pq[r_pi];
                            r_ovalid <= 1'b1; r_olast <= 1'b0;
                            r_state <= S_OUT;
                        end
                    end
                end
                S_FINAL: begin
                    r_obyte <= 8'd0; r_ovalid <= 1'b0; r_olast <= 1'b1;
                    r_state <= S_OUT;
                end
                S_OUT: begin
                    if (m_axis_tready) begin
                        if (r_olast) begin
                            r_hcnt <= 2'd0; r_raw <= 17'd0;
                            r_chars <= 16'd0; r_ovf <= 1'b0; r_lead <= 1'b0;
                            r_state <= S_IDLE;
                        end else r_state <= S_EMIT;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    `STD_ASSERT_IMPL(a_out_busy, i_clk, i_rst_n, m_axis_tvalid, !s_axis_tready)
    `STD_ASSERT_IMPL(a_last_novalid, i_clk, i_rst_n,
        m_axis_tvalid && m_axis_tlast, !m_axis_tuser)
    `STD_ASSERT_NEXT(a_raw_cap, i_clk, i_rst_n, r_state == S_ENTRY,
        18'(r_raw) < w_cap || r_raw == 17'd0 || r_ovf)
endmodule
`default_nettype wire
